### hdl/srff_pkg.sv
// shared types, constants and sequence compare helper for the flush filter
package srff_pkg;

	localparam int SEQ_W = 23;
	localparam int OP_W = 2;
	localparam int FLUSH_SLOTS_DEF = 4;

	typedef enum logic [OP_W-1:0] {
		OP_BLOCK = 2'd0,
		OP_FLUSH = 2'd1,
		OP_DEFER = 2'd2
	} op_t;

	// token walking the slot chain with the running drop and claim flags
	typedef struct packed {
		logic tok;
		logic drop;
		logic claim;
	} link_t;

	// true when a is at or past b in modulo-2^23 sequence space
	function automatic logic seq_reached(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
		logic [SEQ_W-1:0] d;
		begin
			d = a - b;
			seq_reached = ~d[SEQ_W-1];
		end
	endfunction

endpackage

### hdl/srff_if.sv
// valid/ready channel interfaces for request and result items
interface srff_in_if;
	logic valid;
	logic ready;
	logic [srff_pkg::OP_W-1:0] op;
	logic [srff_pkg::SEQ_W-1:0] block_seq;
	logic [srff_pkg::SEQ_W-1:0] range_start;
	logic [srff_pkg::SEQ_W-1:0] range_end;

	modport source (output valid, output op, output block_seq, output range_start,
		output range_end, input ready);
	modport sink (input valid, input op, input block_seq, input range_start,
		input range_end, output ready);
endinterface

interface srff_out_if;
	logic valid;
	logic ready;
	logic drop_block;
	logic immediate_done;
	logic request_rejected;

	modport source (output valid, output drop_block, output immediate_done,
		output request_rejected, input ready);
	modport sink (input valid, input drop_block, input immediate_done,
		input request_rejected, output ready);
endinterface

### hdl/srff_cell.sv
// one deferred flush slot of the chain, acting when the token passes through
module srff_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic clear_all,
	input  logic [srff_pkg::OP_W-1:0] op,
	input  logic [srff_pkg::SEQ_W-1:0] block_seq,
	input  logic [srff_pkg::SEQ_W-1:0] range_start,
	input  logic [srff_pkg::SEQ_W-1:0] range_end,
	input  srff_pkg::link_t link_in,
	output srff_pkg::link_t link_out
);

	logic used_q;
	logic active_q;
	logic [srff_pkg::SEQ_W-1:0] start_q;
	logic [srff_pkg::SEQ_W-1:0] end_q;
	srff_pkg::link_t link_q;

	logic is_block;
	logic is_defer;
	logic hit_start;
	logic retire;
	logic take;
	srff_pkg::link_t link_d;

	always_comb begin
		is_block = (op == srff_pkg::OP_BLOCK);
		is_defer = (op == srff_pkg::OP_DEFER);
		hit_start = (start_q == block_seq) && (end_q != block_seq);
		// end equal or overshot
		retire = srff_pkg::seq_reached(block_seq, end_q);
		take = link_in.tok && is_defer && !used_q && !link_in.claim;
		link_d.tok = link_in.tok;
		link_d.drop = link_in.drop
			| (is_block & used_q & (hit_start | (~retire & (active_q | hit_start))));
		link_d.claim = link_in.claim | (is_defer & ~used_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			active_q <= 1'b0;
			link_q <= '0;
		end else begin
			link_q <= link_d;
			if (clear_all) begin
				used_q <= 1'b0;
				active_q <= 1'b0;
			end else if (link_in.tok && is_block && used_q) begin
				if (retire) begin
					used_q <= 1'b0;
					active_q <= 1'b0;
				end else if (hit_start) begin
					active_q <= 1'b1;
				end
			end else if (take) begin
				used_q <= 1'b1;
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			start_q <= range_start;
			end_q <= range_end;
		end
	end

	assign link_out = link_q;

endmodule

### hdl/sequence_range_flush_filter.sv
// top level: immediate flush control, slot chain and result registers
//
// in_item carries one request item: an audio block (op 0), an immediate flush
// arm (op 1) or a deferred flush request (op 2). out_item returns exactly one
// result item per request: drop_block, immediate_done and request_rejected.
// One item is in work at a time. After acceptance a token walks the row of
// FLUSH_SLOTS slot cells, one cell per cycle, and collects the drop flag and
// the lowest free slot claim; the token passes a start register before the
// row, the result is caught in a holding register behind the last cell and
// then moves into the output register, and in_item.ready rises again as the
// result enters the output register.
// Reset clears the pending immediate flush and all slots; in_item.ready is
// high right after reset. When the receiver stalls, the result waits in the
// output register while the next item is accepted and worked on; a second
// finished result is held internally and in_item.ready stays low until it
// moves on.
module sequence_range_flush_filter #(
	parameter int FLUSH_SLOTS = srff_pkg::FLUSH_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	srff_in_if.sink in_item,
	srff_out_if.source out_item
);

	logic busy_q;
	logic accept;

	logic [srff_pkg::OP_W-1:0] op_q;
	logic [srff_pkg::SEQ_W-1:0] seq_q;
	logic [srff_pkg::SEQ_W-1:0] rs_q;
	logic [srff_pkg::SEQ_W-1:0] re_q;

	logic imm_pend_q;
	logic [srff_pkg::SEQ_W-1:0] imm_end_q;
	logic imm_reached;
	logic in_block;
	logic clear_all;
	logic done_q;

	srff_pkg::link_t start_q;
	srff_pkg::link_t link [0:FLUSH_SLOTS];

	logic res_valid_q;
	logic res_drop_q;
	logic res_done_q;
	logic res_rej_q;
	logic move;

	logic out_valid_q;
	logic out_drop_q;
	logic out_done_q;
	logic out_rej_q;

	assign in_item.ready = ~busy_q;
	assign accept = in_item.valid & ~busy_q;
	assign in_block = (in_item.op == srff_pkg::OP_BLOCK);
	assign imm_reached = srff_pkg::seq_reached(in_item.block_seq, imm_end_q);
	// flush end reached: every deferred slot is dropped as well
	assign clear_all = accept & in_block & imm_pend_q & imm_reached;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= in_item.op;
			seq_q <= in_item.block_seq;
			rs_q <= in_item.range_start;
			re_q <= in_item.range_end;
			done_q <= clear_all;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			imm_pend_q <= 1'b0;
			imm_end_q <= '0;
			start_q <= '0;
		end else begin
			start_q.tok <= accept;
			start_q.drop <= accept & in_block & imm_pend_q & ~imm_reached;
			start_q.claim <= 1'b0;
			if (accept) begin
				case (in_item.op)
					srff_pkg::OP_BLOCK: begin
						if (imm_pend_q && imm_reached) begin
							imm_pend_q <= 1'b0;
						end
					end
					srff_pkg::OP_FLUSH: begin
						imm_pend_q <= 1'b1;
						imm_end_q <= in_item.range_end;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign link[0] = start_q;

	for (genvar i = 0; i < FLUSH_SLOTS; i++) begin : g_cell
		srff_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.clear_all  (clear_all),
			.op         (op_q),
			.block_seq  (seq_q),
			.range_start(rs_q),
			.range_end  (re_q),
			.link_in    (link[i]),
			.link_out   (link[i+1])
		);
	end

	assign move = res_valid_q & (~out_valid_q | out_item.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (move) begin
				busy_q <= 1'b0;
			end
			if (link[FLUSH_SLOTS].tok) begin
				res_valid_q <= 1'b1;
			end else if (move) begin
				res_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_item.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (link[FLUSH_SLOTS].tok) begin
			res_drop_q <= link[FLUSH_SLOTS].drop;
			res_done_q <= done_q;
			res_rej_q <= (op_q == srff_pkg::OP_DEFER) & ~link[FLUSH_SLOTS].claim;
		end
		if (move) begin
			out_drop_q <= res_drop_q;
			out_done_q <= res_done_q;
			out_rej_q <= res_rej_q;
		end
	end

	assign out_item.valid = out_valid_q;
	assign out_item.drop_block = out_drop_q;
	assign out_item.immediate_done = out_done_q;
	assign out_item.request_rejected = out_rej_q;

endmodule
